// ===== design/co2rx_pkg.sv =====
// ============================================================================
// co2rx_pkg
// Constants shared by the CO2 sensor response frame receiver.
// ============================================================================
package co2rx_pkg;

    localparam int unsigned FRAME_LEN = 9;
    localparam int unsigned CNT_W     = $clog2(FRAME_LEN + 1);

    localparam logic [CNT_W-1:0] POS_IDLE = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_HIGH = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_LOW  = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_CSUM = CNT_W'(FRAME_LEN - 1);

    localparam logic [7:0] START_BYTE = 8'hFF;

    typedef logic [CNT_W-1:0] pos_t;

endpackage

// ===== design/co2_sensor_frame_receiver_top.sv =====
// ============================================================================
// co2_sensor_frame_receiver_top
// Parses nine-byte sensor response frames from a byte stream and emits the
// concentration of each frame whose checksum matches.
// ============================================================================
// Path: an accepted input word passes the input register, then the frame counter /
//   running sum update into the result register that drives m_axis_tvalid.
// Throughput: one byte per cycle unless the output stalls; counter and 8-bit sum update together.
// Reset (rst_n low, async): hunting for a start byte, sum and captured bytes
//   cleared, both pipeline registers empty.
module co2_sensor_frame_receiver_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] co2_ppm
);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    co2rx_pkg::pos_t     pos_reg,  pos_next;
    logic [7:0]          sum_reg,  sum_next;
    logic [7:0]          high_reg, high_next;
    logic [7:0]          low_reg,  low_next;
    logic                out_valid_reg;
    logic [15:0]         out_data_reg;

    logic                out_free;
    logic                proc;
    logic                emit;
    logic [7:0]          expect_sum;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || proc;
    assign expect_sum    = 8'h00 - sum_reg;

    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        high_next = high_reg;
        low_next  = low_reg;
        emit      = 1'b0;
        if (proc)
        begin
            if (pos_reg == co2rx_pkg::POS_IDLE)
            begin
                if (in_byte_reg == co2rx_pkg::START_BYTE)
                begin
                    pos_next = co2rx_pkg::pos_t'(1);
                    sum_next = 8'h00;
                end
            end
            else if (pos_reg > co2rx_pkg::POS_CSUM)
            begin
                pos_next = co2rx_pkg::POS_IDLE;
                sum_next = 8'h00;
            end
            else if (pos_reg == co2rx_pkg::POS_CSUM)
            begin
                pos_next = co2rx_pkg::POS_IDLE;
                sum_next = 8'h00;
                emit     = (in_byte_reg == expect_sum);
            end
            else
            begin
                sum_next = sum_reg + in_byte_reg;
                if (pos_reg == co2rx_pkg::POS_HIGH)
                    high_next = in_byte_reg;
                else if (pos_reg == co2rx_pkg::POS_LOW)
                    low_next = in_byte_reg;
                pos_next = pos_reg + co2rx_pkg::pos_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= co2rx_pkg::POS_IDLE;
            sum_reg       <= 8'h00;
            high_reg      <= 8'h00;
            low_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            high_reg <= high_next;
            low_reg  <= low_next;
            if (out_free)
                out_valid_reg <= emit;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
        if (emit)
            out_data_reg <= {high_reg, low_reg};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // counter stays inside the frame
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= co2rx_pkg::POS_CSUM)
        else $error("frame counter out of range");

    // a result only comes from the checksum byte
    a_emit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (proc && pos_reg == co2rx_pkg::POS_CSUM))
        else $error("result outside checksum byte");

    // checksum byte always returns to hunting, sum cleared
    a_csum_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && pos_reg == co2rx_pkg::POS_CSUM)
        |=> (pos_reg == co2rx_pkg::POS_IDLE && sum_reg == 8'h00))
        else $error("no return to idle after checksum byte");

    // a new result is loaded only into a free output slot
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !emit)
        else $error("result produced while output stalled");

endmodule
